/* rtl/core/dmvl_pkg.sv */
// shared constants and types of the dual-motor velocity loop
// used by dmvl_target_scale, dmvl_lane and dual_motor_ip_velocity_loop
package dmvl_pkg;

    // 8.8 fixed point
    localparam int FRAC_BITS = 8;
    localparam int TICK_RATE_DEF = 100;

    // operating modes
    localparam logic [1:0] MODE_HOLD   = 2'd0;
    localparam logic [1:0] MODE_CLOSED = 2'd1;
    localparam logic [1:0] MODE_OPEN   = 2'd2;

    // register indexes
    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_TARGET_A = 3'd1;
    localparam logic [2:0] REG_TARGET_B = 3'd2;
    localparam logic [2:0] REG_GAIN_P   = 3'd3;
    localparam logic [2:0] REG_GAIN_I   = 3'd4;
    localparam logic [2:0] REG_WINDUP   = 3'd5;

    // pipeline load strobes and the closed-mode flag from the top level to each lane
    typedef struct packed {
        logic load_s1;
        logic load_s2;
        logic closed;
    } lane_ctrl_t;

endpackage

/* rtl/core/dmvl_target_scale.sv */
// scaled target: (|target| << 8) / TICK_RATE, low 16 bits, three register stages
// uses dmvl_pkg; instantiated once per lane by the top level
module dmvl_target_scale #(
    parameter int TICK_RATE = dmvl_pkg::TICK_RATE_DEF
) (
    input  logic               aclk,
    input  logic signed [15:0] target,
    output logic        [15:0] scaled
);
    import dmvl_pkg::*;

    localparam int X_W    = 16 + FRAC_BITS;
    localparam int SHIFT  = 31;
    localparam int RATE_W = $clog2(TICK_RATE + 1);
    localparam logic [31:0] RECIP = 32'((64'd1 << SHIFT) / TICK_RATE);
    localparam logic [RATE_W-1:0] RATE = RATE_W'(TICK_RATE);

    logic [15:0]        mag;
    logic [X_W-1:0]     x;
    logic [X_W+31:0]    prod_next;
    logic [X_W+31:0]    prod_reg;
    logic [X_W-1:0]     x_reg;
    logic [X_W-1:0]     q_est;
    logic [X_W-1:0]     rem;
    logic [X_W-1:0]     q_reg;
    logic [X_W-1:0]     rem_reg;
    logic [15:0]        scaled_reg;

    // magnitude of the signed target, most negative maps to 32768
    assign mag = target[15] ? 16'(-target) : 16'(target);
    assign x = {mag, {FRAC_BITS{1'b0}}};
    assign prod_next = (X_W + 32)'(x) * (X_W + 32)'(RECIP);

    // quotient estimate is exact or one short
    assign q_est = prod_reg[SHIFT +: X_W];
    assign rem = x_reg - X_W'(q_est * X_W'(RATE));

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        x_reg    <= x;
        q_reg    <= q_est;
        rem_reg  <= rem;
        // one correction step
        if (rem_reg >= X_W'(RATE)) begin
            scaled_reg <= 16'(q_reg + 1'b1);
        end else begin
            scaled_reg <= q_reg[15:0];
        end
    end

    assign scaled = scaled_reg;

endmodule

/* rtl/core/dmvl_lane.sv */
// one controller lane: integral with windup clamp, gain products, speed
// uses dmvl_pkg; two of these feed the merge stage of the top level
module dmvl_lane #(
    parameter int TICK_RATE = dmvl_pkg::TICK_RATE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dmvl_pkg::lane_ctrl_t ctrl,
    input  logic [7:0]           count,
    input  logic [15:0]          scaled,
    input  logic                 dir_neg,
    input  logic [15:0]          gain_p,
    input  logic [15:0]          gain_i,
    input  logic [15:0]          windup_limit,
    output logic [7:0]           drive_closed,
    output logic [7:0]           drive_open,
    output logic [15:0]          speed
);
    import dmvl_pkg::*;

    localparam int RATE_W = $clog2(TICK_RATE + 1);
    localparam logic [RATE_W-1:0] RATE = RATE_W'(TICK_RATE);

    logic [15:0] fb;
    logic [15:0] err;
    logic [15:0] sum;
    logic [15:0] accum_next;
    logic [15:0] accum_reg;
    logic [15:0] spd_mag;
    logic [15:0] spd_next;

    logic [15:0] acc_s1_reg;
    logic [15:0] fb_s1_reg;
    logic [15:0] spd_s1_reg;
    logic [7:0]  open_s1_reg;
    logic [15:0] pi_s2_reg;
    logic [15:0] pf_s2_reg;
    logic [15:0] spd_s2_reg;
    logic [7:0]  open_s2_reg;
    logic [15:0] pi_sum;

    // error and clamped integral
    assign fb = {count, {FRAC_BITS{1'b0}}};
    assign err = scaled - fb;
    assign sum = accum_reg + err;
    assign accum_next = (sum > windup_limit) ? windup_limit : sum;

    // measured velocity with sign from the direction
    assign spd_mag = 16'(16'(count) * 16'(RATE));
    assign spd_next = dir_neg ? 16'(-spd_mag) : spd_mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg <= '0;
        end else if (ctrl.load_s1 && ctrl.closed) begin
            accum_reg <= accum_next;
        end
    end

    // stage 1: integral and feedback
    always_ff @(posedge aclk) begin
        if (ctrl.load_s1) begin
            acc_s1_reg  <= accum_next;
            fb_s1_reg   <= fb;
            spd_s1_reg  <= spd_next;
            open_s1_reg <= scaled[15:8];
        end
    end

    // stage 2: gain products, low 16 bits kept
    always_ff @(posedge aclk) begin
        if (ctrl.load_s2) begin
            pi_s2_reg   <= 16'(acc_s1_reg * gain_i);
            pf_s2_reg   <= 16'(fb_s1_reg * gain_p);
            spd_s2_reg  <= spd_s1_reg;
            open_s2_reg <= open_s1_reg;
        end
    end

    assign pi_sum = pi_s2_reg + pf_s2_reg;
    assign drive_closed = pi_sum[15:8];
    assign drive_open = open_s2_reg;
    assign speed = spd_s2_reg;

endmodule

/* rtl/core/dual_motor_ip_velocity_loop.sv */
// Dual-motor I-P velocity loop. One input beat carries the encoder counts of
// both motors; one output beat follows with two drive commands and two signed
// speeds. Both lanes run in parallel and a new beat is taken every cycle
// while s_tready is high; each beat passes through the integral stage, the
// gain product stage and the output register. The scaled target is produced
// by a three-stage reciprocal divider per lane, so after every configuration
// write the input side holds s_tready low while that divider settles; the
// same holds after reset.
// depends on dmvl_pkg, dmvl_target_scale and dmvl_lane
module dual_motor_ip_velocity_loop #(
    parameter int TICK_RATE = dmvl_pkg::TICK_RATE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input beat
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // count_a [7:0], count_b [15:8]
    // result beat
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // drive_a, drive_b, speed_a, speed_b
);
    import dmvl_pkg::*;

    localparam logic [2:0] SETTLE = 3'd4;

    logic [1:0]  mode_reg;
    logic [15:0] target_a_reg;
    logic [15:0] target_b_reg;
    logic [15:0] gain_p_reg;
    logic [15:0] gain_i_reg;
    logic [15:0] windup_reg;
    logic [2:0]  settle_reg;

    logic        v1_reg, v2_reg, v3_reg;
    logic        rdy1, rdy2, rdy3;
    logic        load1, load2, load3;
    logic [1:0]  mode_s1_reg, mode_s2_reg;

    logic [15:0] scaled_a, scaled_b;
    lane_ctrl_t  ctrl;
    logic [7:0]  dc_a, dc_b, do_a, do_b;
    logic [15:0] sp_a, sp_b;

    logic [7:0]  drive_a_reg, drive_b_reg;
    logic [15:0] speed_a_reg, speed_b_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_HOLD;
            target_a_reg <= '0;
            target_b_reg <= '0;
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            windup_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MODE:     mode_reg     <= cfg_wdata[1:0];
                REG_TARGET_A: target_a_reg <= cfg_wdata;
                REG_TARGET_B: target_b_reg <= cfg_wdata;
                REG_GAIN_P:   gain_p_reg   <= cfg_wdata;
                REG_GAIN_I:   gain_i_reg   <= cfg_wdata;
                REG_WINDUP:   windup_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // hold off input until the target dividers have caught up
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            settle_reg <= SETTLE;
        end else if (settle_reg != 3'd0) begin
            settle_reg <= settle_reg - 3'd1;
        end
    end

    // pipeline handshake
    assign rdy3 = !v3_reg || m_tready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1 && (settle_reg == 3'd0);
    assign load1 = s_tvalid && s_tready;
    assign load2 = v1_reg && rdy2;
    assign load3 = v2_reg && rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (load1) begin
                v1_reg <= 1'b1;
            end else if (load2) begin
                v1_reg <= 1'b0;
            end
            if (load2) begin
                v2_reg <= 1'b1;
            end else if (load3) begin
                v2_reg <= 1'b0;
            end
            if (load3) begin
                v3_reg <= 1'b1;
            end else if (m_tready) begin
                v3_reg <= 1'b0;
            end
        end
    end

    // mode travels with the beat
    always_ff @(posedge aclk) begin
        if (load1) begin
            mode_s1_reg <= mode_reg;
        end
        if (load2) begin
            mode_s2_reg <= mode_s1_reg;
        end
    end

    assign ctrl.load_s1 = load1;
    assign ctrl.load_s2 = load2;
    assign ctrl.closed  = (mode_reg == MODE_CLOSED);

    dmvl_target_scale #(.TICK_RATE(TICK_RATE)) u_scale_a (
        .aclk   (aclk),
        .target (target_a_reg),
        .scaled (scaled_a)
    );

    dmvl_target_scale #(.TICK_RATE(TICK_RATE)) u_scale_b (
        .aclk   (aclk),
        .target (target_b_reg),
        .scaled (scaled_b)
    );

    dmvl_lane #(.TICK_RATE(TICK_RATE)) u_lane_a (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .count        (s_tdata[7:0]),
        .scaled       (scaled_a),
        .dir_neg      (target_a_reg[15]),
        .gain_p       (gain_p_reg),
        .gain_i       (gain_i_reg),
        .windup_limit (windup_reg),
        .drive_closed (dc_a),
        .drive_open   (do_a),
        .speed        (sp_a)
    );

    dmvl_lane #(.TICK_RATE(TICK_RATE)) u_lane_b (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .count        (s_tdata[15:8]),
        .scaled       (scaled_b),
        .dir_neg      (target_b_reg[15]),
        .gain_p       (gain_p_reg),
        .gain_i       (gain_i_reg),
        .windup_limit (windup_reg),
        .drive_closed (dc_b),
        .drive_open   (do_b),
        .speed        (sp_b)
    );

    // merge stage: output register doubles as the last reported values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_a_reg <= '0;
            drive_b_reg <= '0;
            speed_a_reg <= '0;
            speed_b_reg <= '0;
        end else if (load3) begin
            unique case (mode_s2_reg)
                MODE_CLOSED: begin
                    drive_a_reg <= dc_a;
                    drive_b_reg <= dc_b;
                    speed_a_reg <= sp_a;
                    speed_b_reg <= sp_b;
                end
                MODE_OPEN: begin
                    drive_a_reg <= do_a;
                    drive_b_reg <= do_b;
                    speed_a_reg <= {8'd0, do_a};
                    speed_b_reg <= {8'd0, do_b};
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {speed_b_reg, speed_a_reg, drive_b_reg, drive_a_reg};

endmodule
